// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the timer wheel RTL. They compile to nothing
// when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/htw_pkg.sv -----
// ----------------------------------------------------------------------------
// htw_pkg
// Types and codes shared by the hashed timer wheel controller and datapath.
// ----------------------------------------------------------------------------
package htw_pkg;

    // Slot numbers, timer ids and command fields have fixed widths.
    localparam int SLOT_W = 4;
    localparam int ID_W   = 4;
    localparam int PER_W  = 16;
    localparam int TCNT_W = 3;

    localparam logic [TCNT_W-1:0] MAX_TICKS = 3'd4;

    // Command kinds.
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_ADD  = 2'd1;
    localparam logic [1:0] KIND_DEL  = 2'd2;

    // Result event codes.
    localparam logic [1:0] EV_FIRE  = 2'd0;
    localparam logic [1:0] EV_ACK   = 2'd1;
    localparam logic [1:0] EV_EMPTY = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_ARMED = 2'd1;
    localparam logic [1:0] STAT_ZERO_PER  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_RESP,
        S_ADV,
        S_SCAN,
        S_FLUSH
    } htw_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic div_start;
        logic arm;
        logic out_ack;
        logic tick_adv;
        logic scan_step;
        logic out_flush;
    } htw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic arm_ok;
        logic div_done;
        logic ticks_done;
        logic scan_last;
        logic scan_stall;
        logic out_free;
    } htw_sts_t;

endpackage

// ----- sv/hashed_timer_wheel_unit.sv -----
// ----------------------------------------------------------------------------
// hashed_timer_wheel_unit
// Periodic timer table on a hashed wheel: add, delete and tick commands in,
// fired timers and acknowledgements out.
//
//   Channel | Handshake          | Words
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_ready  | kind, timer_id, period, tick_count
//   out     | out_valid/out_ready| event_res, fired_id, status, last
//
// An arming add passes accept, execute, the reciprocal divider that splits the
// period into rounds and slot offset, and the response; other non-tick words
// pass accept, execute and response. A tick word is accepted and executed, then
// each of its n wheel ticks advances the wheel and scans the table, one table
// entry examined per cycle unless a full result register stalls the scan at the
// next fire and holds back the final word. Reset clears the control state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hashed_timer_wheel_unit
    import htw_pkg::*;
#(
    parameter int WHEEL_SLOTS = 10,
    parameter int MAX_TIMERS  = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [ID_W-1:0]    timer_id,
    input  logic [PER_W-1:0]   period,
    input  logic [TCNT_W-1:0]  tick_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         event_res,
    output logic [ID_W-1:0]    fired_id,
    output logic [1:0]         status,
    output logic               last
);

    htw_cmd_t cmd;
    htw_sts_t sts;

    htw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    htw_dp #(
        .WHEEL_SLOTS (WHEEL_SLOTS),
        .MAX_TIMERS  (MAX_TIMERS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .kind       (kind),
        .timer_id   (timer_id),
        .period     (period),
        .tick_count (tick_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_res  (event_res),
        .fired_id   (fired_id),
        .status     (status),
        .last       (last)
    );

    `ASSERT_IMP(a_out_load_free, clk, rst_n, cmd.out_ack || cmd.out_flush, sts.out_free)
    `ASSERT_IMP(a_scan_no_stall, clk, rst_n, cmd.scan_step, !sts.scan_stall)
    `ASSERT_IMP(a_arm_after_div, clk, rst_n, cmd.arm, sts.div_done && sts.arm_ok)
    `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

// ----- sv/htw_div.sv -----
// ----------------------------------------------------------------------------
// htw_div
// Division by the constant wheel size through a reciprocal multiplication;
// the quotient is registered first and the remainder is then registered from it.
// ----------------------------------------------------------------------------
module htw_div
    import htw_pkg::*;
#(
    parameter int WHEEL_SLOTS = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [PER_W-1:0]   dividend,
    output logic [PER_W-1:0]   quot,
    output logic [SLOT_W-1:0]  rem,
    output logic               done
);

    // With k = PER_W + clog2(d) and m = ceil(2^k / d), floor(x * m / 2^k)
    // equals floor(x / d) for every dividend that fits in PER_W bits.
    localparam int RSH = PER_W + $clog2(WHEEL_SLOTS);
    localparam longint unsigned RECIP_L =
        ((64'd1 << RSH) + 64'(WHEEL_SLOTS) - 64'd1) / 64'(WHEEL_SLOTS);
    localparam logic [PER_W:0]   RECIP   = (PER_W+1)'(RECIP_L);
    localparam logic [PER_W-1:0] DIVISOR = PER_W'(WHEEL_SLOTS);

    logic               stage_reg;
    logic               done_reg;
    logic [PER_W-1:0]   x_reg;
    logic [PER_W-1:0]   q_reg;
    logic [SLOT_W-1:0]  r_reg;
    logic [2*PER_W:0]   prod;
    logic [PER_W-1:0]   q_prod;

    always_comb
    begin
        prod   = {{(PER_W+1){1'b0}}, dividend} * {{PER_W{1'b0}}, RECIP};
        q_prod = PER_W'(prod >> RSH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= dividend;
            q_reg <= q_prod;
        end
        if (stage_reg)
        begin
            r_reg <= SLOT_W'(x_reg - q_reg * DIVISOR);
        end
    end

    assign quot = q_reg;
    assign rem  = r_reg;
    assign done = done_reg;

endmodule

// ----- sv/htw_dp.sv -----
// ----------------------------------------------------------------------------
// htw_dp
// Timer table, wheel position, pending fire and result register.
// ----------------------------------------------------------------------------
module htw_dp
    import htw_pkg::*;
#(
    parameter int WHEEL_SLOTS = 10,
    parameter int MAX_TIMERS  = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  htw_cmd_t           cmd,
    output htw_sts_t           sts,
    input  logic [1:0]         kind,
    input  logic [ID_W-1:0]    timer_id,
    input  logic [PER_W-1:0]   period,
    input  logic [TCNT_W-1:0]  tick_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         event_res,
    output logic [ID_W-1:0]    fired_id,
    output logic [1:0]         status,
    output logic               last
);

    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(MAX_TIMERS - 1);
    localparam logic [ID_W:0]     NUM_IDS  = (ID_W+1)'(MAX_TIMERS);
    localparam logic [SLOT_W:0]   WS       = (SLOT_W+1)'(WHEEL_SLOTS);

    // Sum of two slot numbers, folded back onto the wheel.
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= WS)
        begin
            s = s - WS;
        end
        return s[SLOT_W-1:0];
    endfunction

    // Item registers.
    logic [1:0]         kind_reg;
    logic [ID_W-1:0]    id_reg;
    logic [PER_W-1:0]   per_reg;
    logic [TCNT_W-1:0]  ticks_left_reg;
    logic [1:0]         resp_stat_reg;

    // Wheel and scan position.
    logic [SLOT_W-1:0]  cur_reg;
    logic [IDX_W-1:0]   idx_reg;

    // Timer table.
    logic               armed_reg   [MAX_TIMERS];
    logic [SLOT_W-1:0]  slot_tab    [MAX_TIMERS];
    logic [PER_W-1:0]   rounds_tab  [MAX_TIMERS];
    logic [PER_W-1:0]   quot_tab    [MAX_TIMERS];
    logic [SLOT_W-1:0]  ofs_tab     [MAX_TIMERS];

    // Fire held back until the next one shows whether it is the last word.
    logic               pend_valid_reg;
    logic [IDX_W-1:0]   pend_id_reg;

    // Result register.
    logic               out_valid_reg;
    logic [1:0]         event_res_reg;
    logic [ID_W-1:0]    fired_id_reg;
    logic [1:0]         status_reg;
    logic               last_reg;

    logic [PER_W-1:0]   div_quot;
    logic [SLOT_W-1:0]  div_rem;
    logic               div_done;

    logic [IDX_W-1:0]   id_idx;
    logic               id_ok;
    logic               hit;
    logic               fire;
    logic               push;
    logic               out_free;
    logic [SLOT_W:0]    ofs_sum;
    logic [SLOT_W-1:0]  arm_ofs;
    logic [SLOT_W-1:0]  cur_inc;
    logic [1:0]         exec_stat;

    htw_div #(
        .WHEEL_SLOTS (WHEEL_SLOTS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (per_reg - 1'b1),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

    always_comb
    begin
        id_idx   = id_reg[IDX_W-1:0];
        id_ok    = ({1'b0, id_reg} < NUM_IDS);
        hit      = armed_reg[idx_reg] && (slot_tab[idx_reg] == cur_reg);
        fire     = hit && (rounds_tab[idx_reg] == '0);
        out_free = !out_valid_reg || out_ready;
        push     = cmd.scan_step && fire && pend_valid_reg;

        // period mod size is ((period - 1) mod size) + 1, wrapped.
        ofs_sum  = {1'b0, div_rem} + 1'b1;
        arm_ofs  = (ofs_sum == WS) ? '0 : ofs_sum[SLOT_W-1:0];
        cur_inc  = slot_add(cur_reg, SLOT_W'(1));

        exec_stat = STAT_OK;
        if (kind_reg == KIND_ADD)
        begin
            if (!id_ok)
            begin
                exec_stat = STAT_NOT_ARMED;
            end
            else if (per_reg == '0)
            begin
                exec_stat = STAT_ZERO_PER;
            end
        end
        else if (kind_reg == KIND_DEL)
        begin
            if (!(id_ok && armed_reg[id_idx]))
            begin
                exec_stat = STAT_NOT_ARMED;
            end
        end

        sts.is_tick    = (kind_reg == KIND_TICK);
        sts.arm_ok     = (kind_reg == KIND_ADD) && id_ok && (per_reg != '0);
        sts.div_done   = div_done;
        sts.ticks_done = (ticks_left_reg == '0);
        sts.scan_last  = (idx_reg == IDX_LAST);
        sts.scan_stall = fire && pend_valid_reg && !out_free;
        sts.out_free   = out_free;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg        <= '0;
            idx_reg        <= '0;
            ticks_left_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_TIMERS; i++)
            begin
                armed_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                ticks_left_reg <= (tick_count > MAX_TICKS) ? MAX_TICKS : tick_count;
            end
            if (cmd.exec && (kind_reg == KIND_DEL) && id_ok)
            begin
                armed_reg[id_idx] <= 1'b0;
            end
            if (cmd.arm)
            begin
                armed_reg[id_idx] <= 1'b1;
            end
            if (cmd.tick_adv)
            begin
                cur_reg        <= cur_inc;
                idx_reg        <= '0;
                ticks_left_reg <= ticks_left_reg - 1'b1;
            end
            if (cmd.scan_step)
            begin
                idx_reg <= (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
                if (fire)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            if (cmd.out_flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.out_ack || push || cmd.out_flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and the timer entries.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            id_reg   <= timer_id;
            per_reg  <= period;
        end
        if (cmd.exec)
        begin
            resp_stat_reg <= exec_stat;
        end
        if (cmd.arm)
        begin
            slot_tab[id_idx]   <= slot_add(cur_reg, arm_ofs);
            rounds_tab[id_idx] <= div_quot;
            quot_tab[id_idx]   <= div_quot;
            ofs_tab[id_idx]    <= arm_ofs;
        end
        if (cmd.scan_step && hit)
        begin
            if (fire)
            begin
                slot_tab[idx_reg]   <= slot_add(cur_reg, ofs_tab[idx_reg]);
                rounds_tab[idx_reg] <= quot_tab[idx_reg];
                pend_id_reg         <= idx_reg;
            end
            else
            begin
                rounds_tab[idx_reg] <= rounds_tab[idx_reg] - 1'b1;
            end
        end
        if (cmd.out_ack)
        begin
            event_res_reg <= EV_ACK;
            fired_id_reg  <= '0;
            status_reg    <= resp_stat_reg;
            last_reg      <= 1'b1;
        end
        else if (push)
        begin
            event_res_reg <= EV_FIRE;
            fired_id_reg  <= ID_W'(pend_id_reg);
            status_reg    <= STAT_OK;
            last_reg      <= 1'b0;
        end
        else if (cmd.out_flush)
        begin
            event_res_reg <= pend_valid_reg ? EV_FIRE : EV_EMPTY;
            fired_id_reg  <= pend_valid_reg ? ID_W'(pend_id_reg) : '0;
            status_reg    <= STAT_OK;
            last_reg      <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_res_reg;
    assign fired_id  = fired_id_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

// ----- sv/htw_ctrl.sv -----
// ----------------------------------------------------------------------------
// htw_ctrl
// Sequencer for command execution, wheel advance and table scan.
// ----------------------------------------------------------------------------
module htw_ctrl
    import htw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  htw_sts_t  sts,
    output htw_cmd_t  cmd
);

    htw_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                priority if (sts.is_tick)
                begin
                    state_next = S_ADV;
                end
                else if (sts.arm_ok)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.arm    = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_ack = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_ADV:
            begin
                if (sts.ticks_done)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.tick_adv = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // A fire waits here while one is pending and the result register is full.
                if (!sts.scan_stall)
                begin
                    cmd.scan_step = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = S_ADV;
                    end
                end
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_flush = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- tb/tb_hashed_timer_wheel_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_timer_wheel_unit
// Self-checking bench for the hashed timer wheel. A table of directed words
// covers the command codes, the period extremes and the odd tick counts. It
// is followed by random add, tick and delete sequences. Every accepted input
// word runs through a local model of the wheel. Each output word is compared
// in order against the model or, for typed table rows, the row's result.
// ----------------------------------------------------------------------------
module tb_hashed_timer_wheel_unit;
    import htw_pkg::*;

    localparam int WHEEL_SLOTS = 10;
    localparam int MAX_TIMERS  = 16;
    localparam int DIR_ROWS    = 23;
    localparam int RAND_WORDS  = 237;
    localparam int DRAIN_WAIT  = 100;

    // Kind three has no package name; the block acknowledges it and does nothing.
    localparam logic [1:0] KIND_NOP = 2'd3;

    typedef struct packed {
        logic [1:0]      ev;
        logic [ID_W-1:0] id;
        logic [1:0]      st;
        logic            lst;
    } wheel_res_t;

    typedef struct packed {
        logic [1:0]        k;
        logic [ID_W-1:0]   tid;
        logic [PER_W-1:0]  per;
        logic [TCNT_W-1:0] tc;
        logic              typed;
        logic [1:0]        xev;
        logic [1:0]        xst;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         kind;
    logic [ID_W-1:0]    timer_id;
    logic [PER_W-1:0]   period;
    logic [TCNT_W-1:0]  tick_count;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         event_res;
    logic [ID_W-1:0]    fired_id;
    logic [1:0]         status;
    logic               last;

    // Typed expectation that travels with the word being driven.
    logic               cur_typed;
    logic [1:0]         cur_xev;
    logic [1:0]         cur_xst;

    // Local copy of the timer table.
    bit                 tm_armed [MAX_TIMERS];
    logic [SLOT_W-1:0]  tm_slot [MAX_TIMERS];
    logic [PER_W-1:0]   tm_rounds [MAX_TIMERS];
    logic [PER_W-1:0]   tm_period [MAX_TIMERS];
    int                 wheel_pos;

    wheel_res_t         step_res [$];
    wheel_res_t         pending_res [$];
    dir_row_t           dir_tab [DIR_ROWS];

    int                 errors = 0;
    int                 burst_left;
    int                 rx_mode = 0;
    int                 rx_cnt = 0;
    int                 rx_phase = 0;

    hashed_timer_wheel_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .timer_id   (timer_id),
        .period     (period),
        .tick_count (tick_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_res  (event_res),
        .fired_id   (fired_id),
        .status     (status),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    function automatic void arm_entry(input int idx, input logic [PER_W-1:0] per);
        tm_armed[idx]  = 1'b1;
        tm_period[idx] = per;
        tm_slot[idx]   = SLOT_W'(((int'(per) % WHEEL_SLOTS) + wheel_pos) % WHEEL_SLOTS);
        tm_rounds[idx] = PER_W'((int'(per) - 1) / WHEEL_SLOTS);
    endfunction

    // Works out the output words of one input word and updates the table.
    task automatic advance_wheel(input logic [1:0] k, input logic [ID_W-1:0] tid,
                                 input logic [PER_W-1:0] per,
                                 input logic [TCNT_W-1:0] tc);
        int         ticks;
        int         t;
        int         i;
        bit         seen [MAX_TIMERS];
        wheel_res_t r;
        step_res.delete();
        r = '0;
        if (k == KIND_TICK)
        begin
            ticks = (tc > MAX_TICKS) ? int'(MAX_TICKS) : int'(tc);
            for (t = 0; t < ticks; t++)
            begin
                wheel_pos = (wheel_pos + 1) % WHEEL_SLOTS;
                // Timers re-armed into this slot must not be looked at twice.
                for (i = 0; i < MAX_TIMERS; i++)
                    seen[i] = tm_armed[i] && (int'(tm_slot[i]) == wheel_pos);
                for (i = 0; i < MAX_TIMERS; i++)
                begin
                    if (seen[i])
                    begin
                        if (tm_rounds[i] == '0)
                        begin
                            arm_entry(i, tm_period[i]);
                            r.ev  = EV_FIRE;
                            r.id  = ID_W'(i);
                            r.st  = STAT_OK;
                            r.lst = 1'b0;
                            step_res = {step_res, r};
                        end
                        else
                        begin
                            tm_rounds[i] = tm_rounds[i] - 1'b1;
                        end
                    end
                end
            end
            if (step_res.size() == 0)
            begin
                r.ev  = EV_EMPTY;
                r.lst = 1'b1;
                step_res = {step_res, r};
            end
            else
            begin
                step_res[step_res.size() - 1].lst = 1'b1;
            end
        end
        else
        begin
            r.ev  = EV_ACK;
            r.lst = 1'b1;
            r.st  = STAT_OK;
            if (k == KIND_ADD)
            begin
                if (per == '0)
                    r.st = STAT_ZERO_PER;
                else
                    arm_entry(int'(tid), per);
            end
            else if (k == KIND_DEL)
            begin
                if (tm_armed[tid])
                    tm_armed[tid] = 1'b0;
                else
                    r.st = STAT_NOT_ARMED;
            end
            step_res = {step_res, r};
        end
    endtask

    // Input acceptance feeds the model; output acceptance is checked in order.
    always @(posedge clk)
    begin
        wheel_res_t x;
        wheel_res_t ty;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                advance_wheel(kind, timer_id, period, tick_count);
                if (cur_typed)
                begin
                    ty     = '0;
                    ty.ev  = cur_xev;
                    ty.st  = cur_xst;
                    ty.lst = 1'b1;
                    pending_res = {pending_res, ty};
                end
                else
                begin
                    pending_res = {pending_res, step_res};
                end
            end
            if (out_valid && out_ready)
            begin
                if (pending_res.size() == 0)
                begin
                    report_mismatch($sformatf("word with nothing pending: ev %0d id %0d",
                                              event_res, fired_id));
                end
                else
                begin
                    x = pending_res.pop_front();
                    if (event_res !== x.ev)
                        report_mismatch($sformatf("event_res expected %0d got %0d",
                                                  x.ev, event_res));
                    if (fired_id !== x.id)
                        report_mismatch($sformatf("fired_id expected %0d got %0d",
                                                  x.id, fired_id));
                    if (status !== x.st)
                        report_mismatch($sformatf("status expected %0d got %0d",
                                                  x.st, status));
                    if (last !== x.lst)
                        report_mismatch($sformatf("last expected %0d got %0d",
                                                  x.lst, last));
                end
            end
        end
    end

    // The receiver picks a new stall pattern whenever its random hold count runs out.
    always @(negedge clk)
    begin
        if (rx_cnt == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_cnt  = $urandom_range(20, 120);
        end
        else
        begin
            rx_cnt = rx_cnt - 1;
        end
        rx_phase = rx_phase + 1;
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (rx_phase % 5) < 2;
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Drives one word, with a random gap between bursts of words.
    task automatic send_word(input logic [1:0] k, input logic [ID_W-1:0] tid,
                             input logic [PER_W-1:0] per,
                             input logic [TCNT_W-1:0] tc, input logic typed,
                             input logic [1:0] xev, input logic [1:0] xst);
        int gap;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(20, 40);
            else
                burst_left = $urandom_range(1, 10);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        kind       <= k;
        timer_id   <= tid;
        period     <= per;
        tick_count <= tc;
        cur_typed  <= typed;
        cur_xev    <= xev;
        cur_xst    <= xst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_plain(input logic [1:0] k, input logic [ID_W-1:0] tid,
                              input logic [PER_W-1:0] per, input logic [TCNT_W-1:0] tc);
        send_word(k, tid, per, tc, 1'b0, EV_ACK, STAT_OK);
    endtask

    initial
    begin
        int  r;
        int  n;
        int  rand_words;
        int  sel;
        bit  drained;
        logic [PER_W-1:0] p;

        burst_left = 0;
        wheel_pos  = 0;
        rand_words = 0;
        drained    = 1'b0;
        foreach (tm_armed[i])
        begin
            tm_armed[i]  = 1'b0;
            tm_slot[i]   = '0;
            tm_rounds[i] = '0;
            tm_period[i] = '0;
        end
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = KIND_TICK;
        timer_id   = '0;
        period     = '0;
        tick_count = '0;
        cur_typed  = 1'b0;
        cur_xev    = EV_ACK;
        cur_xst    = STAT_OK;

        dir_tab[0]  = '{KIND_TICK, 4'd0,  16'd0,     3'd1, 1'b1, EV_EMPTY, STAT_OK};
        dir_tab[1]  = '{KIND_DEL,  4'd3,  16'd0,     3'd0, 1'b1, EV_ACK, STAT_NOT_ARMED};
        dir_tab[2]  = '{KIND_ADD,  4'd0,  16'd0,     3'd0, 1'b1, EV_ACK, STAT_ZERO_PER};
        dir_tab[3]  = '{KIND_NOP,  4'd9,  16'hFFFF,  3'd7, 1'b1, EV_ACK, STAT_OK};
        dir_tab[4]  = '{KIND_ADD,  4'd0,  16'd1,     3'd0, 1'b1, EV_ACK, STAT_OK};
        dir_tab[5]  = '{KIND_ADD,  4'd15, 16'hFFFF,  3'd0, 1'b1, EV_ACK, STAT_OK};
        dir_tab[6]  = '{KIND_ADD,  4'd5,  16'd10,    3'd0, 1'b1, EV_ACK, STAT_OK};
        dir_tab[7]  = '{KIND_ADD,  4'd6,  16'd20,    3'd0, 1'b1, EV_ACK, STAT_OK};
        dir_tab[8]  = '{KIND_ADD,  4'd7,  16'd3,     3'd0, 1'b1, EV_ACK, STAT_OK};
        dir_tab[9]  = '{KIND_ADD,  4'd8,  16'hAAAA,  3'd0, 1'b1, EV_ACK, STAT_OK};
        dir_tab[10] = '{KIND_ADD,  4'd9,  16'h5555,  3'd0, 1'b1, EV_ACK, STAT_OK};
        dir_tab[11] = '{KIND_TICK, 4'd0,  16'd0,     3'd0, 1'b1, EV_EMPTY, STAT_OK};
        dir_tab[12] = '{KIND_TICK, 4'd0,  16'd0,     3'd7, 1'b0, EV_ACK, STAT_OK};
        dir_tab[13] = '{KIND_TICK, 4'd0,  16'd0,     3'd4, 1'b0, EV_ACK, STAT_OK};
        dir_tab[14] = '{KIND_ADD,  4'd0,  16'd2,     3'd0, 1'b1, EV_ACK, STAT_OK};
        dir_tab[15] = '{KIND_TICK, 4'd0,  16'd0,     3'd5, 1'b0, EV_ACK, STAT_OK};
        dir_tab[16] = '{KIND_DEL,  4'd7,  16'd0,     3'd0, 1'b1, EV_ACK, STAT_OK};
        dir_tab[17] = '{KIND_DEL,  4'd7,  16'd0,     3'd0, 1'b1, EV_ACK, STAT_NOT_ARMED};
        dir_tab[18] = '{KIND_TICK, 4'd0,  16'd0,     3'd6, 1'b0, EV_ACK, STAT_OK};
        dir_tab[19] = '{KIND_TICK, 4'd0,  16'd0,     3'd3, 1'b0, EV_ACK, STAT_OK};
        dir_tab[20] = '{KIND_TICK, 4'd0,  16'd0,     3'd2, 1'b0, EV_ACK, STAT_OK};
        dir_tab[21] = '{KIND_TICK, 4'd0,  16'd0,     3'd4, 1'b0, EV_ACK, STAT_OK};
        dir_tab[22] = '{KIND_DEL,  4'd15, 16'd0,     3'd0, 1'b1, EV_ACK, STAT_OK};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++)
            send_word(dir_tab[r].k, dir_tab[r].tid, dir_tab[r].per, dir_tab[r].tc,
                      dir_tab[r].typed, dir_tab[r].xev, dir_tab[r].xst);

        while (rand_words < RAND_WORDS)
        begin
            if (!drained && rand_words >= RAND_WORDS / 2)
            begin
                // Hold the input off until the wheel has delivered everything.
                @(negedge clk);
                in_valid <= 1'b0;
                while (pending_res.size() != 0)
                    @(posedge clk);
                drained = 1'b1;
            end
            sel = $urandom_range(0, 19);
            if (sel < 12)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    if ($urandom_range(0, 7) == 0)
                        p = PER_W'($urandom_range(41, 400));
                    else
                        p = PER_W'($urandom_range(1, 40));
                    send_plain(KIND_ADD, ID_W'($urandom_range(0, 15)), p, 3'($urandom));
                    rand_words++;
                end
                n = $urandom_range(1, 5);
                repeat (n)
                begin
                    if ($urandom_range(0, 5) == 0)
                        send_plain(KIND_TICK, 4'($urandom), 16'($urandom),
                                   3'($urandom_range(0, 7)));
                    else
                        send_plain(KIND_TICK, 4'($urandom), 16'($urandom),
                                   3'($urandom_range(1, 4)));
                    rand_words++;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    send_plain(KIND_DEL, ID_W'($urandom_range(0, 15)), 16'($urandom),
                               3'($urandom));
                    rand_words++;
                end
            end
            else if (sel == 12)
            begin
                // Every timer lands in the next slot or two, so one tick word
                // brings out a long train of fired words.
                for (n = 0; n < MAX_TIMERS; n++)
                    send_plain(KIND_ADD, ID_W'(n), PER_W'($urandom_range(1, 2)),
                               3'($urandom));
                send_plain(KIND_TICK, 4'($urandom), 16'($urandom), 3'd7);
                rand_words += MAX_TIMERS + 1;
            end
            else if (sel < 16)
            begin
                send_plain(KIND_DEL, ID_W'($urandom_range(0, 15)), 16'($urandom),
                           3'($urandom));
                rand_words++;
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    p = '0;
                else
                    p = PER_W'($urandom);
                send_plain(2'($urandom_range(0, 3)), ID_W'($urandom_range(0, 15)), p,
                           3'($urandom_range(0, 7)));
                rand_words++;
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("hashed_timer_wheel_unit test passed");
        else
            $display("hashed_timer_wheel_unit test failed");
        $finish;
    end

    initial
    begin
        #1200000;
        $display("hashed_timer_wheel_unit test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/htw_pkg.sv
sv/htw_div.sv
sv/htw_dp.sv
sv/htw_ctrl.sv
sv/hashed_timer_wheel_unit.sv
tb/tb_hashed_timer_wheel_unit.sv
